>>> rtl/wwr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wwr_pkg
// Shared constants and helpers of the whole-word replacer.
// ---------------------------------------------------------------------------
package wwr_pkg;

  localparam int BYTE_W       = 8;
  localparam int WORD_BYTES   = 8;
  localparam int LEN_W        = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int MAX_WORD_DEF = 8;

  // delimiters
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_WORD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN  = 2'd3;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    return (v > LEN_W'(WORD_BYTES)) ? LEN_W'(WORD_BYTES) : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/wwr_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wwr_cell
// One byte slot of the word shift chain, with its compare against the
// expected pattern byte.
// ---------------------------------------------------------------------------
module wwr_cell import wwr_pkg::*; (
  input  logic              clk_i,
  input  logic              shift_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [BYTE_W-1:0] expect_i,
  output logic [BYTE_W-1:0] byte_o,
  output logic              match_o
);

  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] byte_d;

  assign byte_d = shift_i ? byte_i : byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o  = byte_q;
  assign match_o = (byte_q == expect_i);

endmodule

`default_nettype wire

>>> rtl/whole_word_replacer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// whole_word_replacer
// Whole-word find and replace over a byte stream.
// ---------------------------------------------------------------------------
// Text enters one byte per transfer on the input channel, stalled while not
// idle; space, period and newline end a word, and so does a byte flagged
// text_end. Word bytes shift into a chain of MAX_WORD byte cells with no
// output. When a word ends, the check state compares it in all cells at once
// against the pattern, then the replacement or the buffered word leaves at
// one byte per cycle while the output is not stalled, through the output
// register, followed by the delimiter if one ended the word. A word longer
// than MAX_WORD leaves unchanged; the byte that overflows the chain and every
// later byte of that word skip the compare. run_last marks the final output
// byte caused by an input byte. Configuration writes are always taken.
// ---------------------------------------------------------------------------
module whole_word_replacer import wwr_pkg::*; #(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [BYTE_W-1:0]     in_byte_i,
  input  logic                  text_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [BYTE_W-1:0]     out_byte_o,
  output logic                  run_last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_WORD + 1);
  localparam int IW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_TAIL  = 2'd3;

  // configuration
  logic [CFG_DATA_W-1:0] pattern_word_q;
  logic [LEN_W-1:0]      pattern_len_q;
  logic [CFG_DATA_W-1:0] replacement_word_q;
  logic [LEN_W-1:0]      replacement_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_word_q     <= '0;
      pattern_len_q      <= LEN_W'(1);
      replacement_word_q <= '0;
      replacement_len_q  <= LEN_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PATTERN_WORD:     pattern_word_q     <= cfg_data_i;
        REG_PATTERN_LEN:      pattern_len_q      <= cfg_data_i[LEN_W-1:0];
        REG_REPLACEMENT_WORD: replacement_word_q <= cfg_data_i;
        REG_REPLACEMENT_LEN:  replacement_len_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              overlong_q, overlong_d;
  logic              tail_q, tail_d;
  logic [BYTE_W-1:0] tail_byte_q, tail_byte_d;
  logic              src_rep_q, src_rep_d;
  logic [LEN_W-1:0]  emit_len_q, emit_len_d;
  logic [2:0]        emit_idx_q, emit_idx_d;
  logic [IW-1:0]     tap_q, tap_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  // shift chain
  logic                  shift;
  logic [BYTE_W-1:0]     cell_byte [MAX_WORD];
  logic [MAX_WORD-1:0]   cell_ok;

  for (genvar j = 0; j < MAX_WORD; j++) begin : g_cell
    logic [LEN_W-1:0]  pidx;
    logic [BYTE_W-1:0] chain_in;
    logic [BYTE_W-1:0] expect_byte;
    logic              eq;

    // byte at cell j is word position count-1-j
    assign pidx        = LEN_W'(count_q) - LEN_W'(j + 1);
    assign expect_byte = pattern_word_q[BYTE_W*pidx[2:0] +: BYTE_W];
    if (j == 0) begin : g_head
      assign chain_in = in_byte_i;
    end else begin : g_link
      assign chain_in = cell_byte[j-1];
    end

    wwr_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .byte_i   (chain_in),
      .expect_i (expect_byte),
      .byte_o   (cell_byte[j]),
      .match_o  (eq)
    );

    assign cell_ok[j] = eq || (LEN_W'(j) >= LEN_W'(count_q));
  end

  logic [LEN_W-1:0] plen_c, rlen_c;
  logic             hit, is_delim, accept, out_free, last_byte;
  logic [BYTE_W-1:0] rep_byte;

  assign plen_c   = clamp_len(pattern_len_q);
  assign rlen_c   = clamp_len(replacement_len_q);
  assign hit      = (count_q != '0) && (LEN_W'(count_q) == plen_c) && (&cell_ok);
  assign is_delim = (in_byte_i == CHAR_SPACE) || (in_byte_i == CHAR_DOT) ||
                    (in_byte_i == CHAR_NL);
  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_byte = ({1'b0, emit_idx_q} == (emit_len_q - LEN_W'(1)));
  assign rep_byte  = replacement_word_q[BYTE_W*emit_idx_q +: BYTE_W];

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    logic [LEN_W-1:0] elen;
    state_d     = state_q;
    count_d     = count_q;
    overlong_d  = overlong_q;
    tail_d      = tail_q;
    tail_byte_d = tail_byte_q;
    src_rep_d   = src_rep_q;
    emit_len_d  = emit_len_q;
    emit_idx_d  = emit_idx_q;
    tap_d       = tap_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    shift       = 1'b0;
    elen        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          tail_byte_d = in_byte_i;
          if (is_delim) begin
            tail_d     = 1'b1;
            overlong_d = 1'b0;
            state_d    = S_CHECK;
          end else if (overlong_q) begin
            tail_d  = 1'b1;
            state_d = S_TAIL;
            if (text_end_i) begin
              overlong_d = 1'b0;
            end
          end else if (count_q == CW'(MAX_WORD)) begin
            // overflow: flush the buffer unchanged, then this byte
            src_rep_d  = 1'b0;
            emit_len_d = LEN_W'(MAX_WORD);
            emit_idx_d = '0;
            tap_d      = IW'(MAX_WORD - 1);
            count_d    = '0;
            tail_d     = 1'b1;
            overlong_d = !text_end_i;
            state_d    = S_EMIT;
          end else begin
            shift   = 1'b1;
            count_d = count_q + CW'(1);
            if (text_end_i) begin
              tail_d  = 1'b0;
              state_d = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        count_d    = '0;
        emit_idx_d = '0;
        tap_d      = IW'(count_q - CW'(1));
        if (hit) begin
          src_rep_d = 1'b1;
          elen      = rlen_c;
        end else begin
          src_rep_d = 1'b0;
          elen      = LEN_W'(count_q);
        end
        emit_len_d = elen;
        if (elen != '0) begin
          state_d = S_EMIT;
        end else if (tail_q) begin
          state_d = S_TAIL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = src_rep_q ? rep_byte : cell_byte[tap_q];
          out_last_d  = last_byte && !tail_q;
          emit_idx_d  = emit_idx_q + 3'd1;
          // buffered bytes walk toward the tap
          shift       = !src_rep_q;
          if (last_byte) begin
            state_d = tail_q ? S_TAIL : S_IDLE;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = tail_byte_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      overlong_q  <= 1'b0;
      tail_q      <= 1'b0;
      src_rep_q   <= 1'b0;
      emit_len_q  <= '0;
      emit_idx_q  <= '0;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      overlong_q  <= overlong_d;
      tail_q      <= tail_d;
      src_rep_q   <= src_rep_d;
      emit_len_q  <= emit_len_d;
      emit_idx_q  <= emit_idx_d;
      tap_q       <= tap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_byte_q <= tail_byte_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;

endmodule

`default_nettype wire
